// ----- hdl/apsp_pkg.sv -----
// ----------------------------------------------------------------------------
// apsp_pkg
// shared types and codes of the all-pairs shortest path engine
// ----------------------------------------------------------------------------
package apsp_pkg;

   // fixed field widths
   localparam int OUT_W  = 40;
   localparam int NC_W   = 7;
   localparam int NODE_W = 6;
   localparam int WGT_W  = 32;

   // register index, taken from paddr bit 2
   localparam logic CSR_IDX_NODE_COUNT = 1'b0;

   typedef enum logic [1:0] {
      FUNC_CLEAR   = 2'd0,
      FUNC_EDGE    = 2'd1,
      FUNC_COMPUTE = 2'd2,
      FUNC_QUERY   = 2'd3
   } func_type;

   typedef struct packed {
      func_type            func;
      logic [NODE_W-1:0]   node_a;
      logic [NODE_W-1:0]   node_b;
      logic [WGT_W-1:0]    weight;
   } req_type;

   typedef struct packed {
      logic [OUT_W-1:0]    distance;
      logic                reachable;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_EDGE_RD,
      ST_EDGE_WAB,
      ST_EDGE_WBA,
      ST_QRY_RD,
      ST_QRY_OUT,
      ST_DIAG,
      ST_IK_RD,
      ST_IK_CHK,
      ST_J_RD,
      ST_J_ADD,
      ST_J_CMP,
      ST_DONE
   } st_type;

endpackage

// ----- hdl/apsp_ram.sv -----
// ----------------------------------------------------------------------------
// apsp_ram
// distance matrix store: one write port, two read ports, registered reads
// ----------------------------------------------------------------------------
module apsp_ram #(
   parameter int ADDR_W = 12,
   parameter int DATA_W = 40
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd0_addr,
   output logic [DATA_W-1:0] rd0_data,
   input  logic [ADDR_W-1:0] rd1_addr,
   output logic [DATA_W-1:0] rd1_data
);

   logic [DATA_W-1:0] ram_ff [0:(1 << ADDR_W)-1];
   logic [DATA_W-1:0] rd0_ff;
   logic [DATA_W-1:0] rd1_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd0_ff <= ram_ff[rd0_addr];
      rd1_ff <= ram_ff[rd1_addr];
   end

   assign rd0_data = rd0_ff;
   assign rd1_data = rd1_ff;

endmodule

// ----- hdl/all_pairs_shortest_path.sv -----
// ----------------------------------------------------------------------------
// all_pairs_shortest_path
// shortest distances between all node pairs of an undirected weighted graph
// ----------------------------------------------------------------------------
// usage:
//   items enter on req_data when start is high and busy is low. each item
//   gives exactly one result on rsp_data, marked by rsp_strobe for a single
//   cycle; the receiver cannot stall, so it must take the result then.
//   the result shows in the first cycle that busy is low again, and a new
//   item may be started in that same cycle.
//   node_count sits at byte address 0 of the apb port (reset value 64);
//   write it only while the block is idle.
// steps per item, n = min(node_count, MAX_NODES), D = 2**(2*clog2(MAX_NODES)):
//   clear    writes all D matrix entries, one matrix entry written per cycle
//   add edge read, write a-b, write b-a; query read, output
//   compute  a sweep over k, i and j below n: one read-add-compare-write step
//            per relaxation through the shared saturating adder
// reset starts a clearing pass that fills all D matrix entries with
// infinity; busy stays high through it and no result comes out of it.
// ----------------------------------------------------------------------------
module all_pairs_shortest_path #(
   parameter int MAX_NODES = 64,
   parameter int DIST_BITS = 40
) (
   input  logic                     clock,
   input  logic                     reset,
   // item channel
   input  logic                     start,
   output logic                     busy,
   input  apsp_pkg::req_type        req_data,
   // result channel
   output logic                     rsp_strobe,
   output apsp_pkg::rsp_type        rsp_data,
   // register port
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [2:0]               paddr,
   input  logic [31:0]              pwdata,
   output logic [31:0]              prdata,
   output logic                     pready
);

   import apsp_pkg::*;

   // index and address widths
   localparam int IDX_W  = $clog2(MAX_NODES);
   localparam int ADDR_W = 2 * IDX_W;
   localparam int CNT_W  = $clog2(MAX_NODES + 1);
   localparam int CMP_W  = (CNT_W > NC_W) ? CNT_W : NC_W;
   localparam int EXT_W  = (DIST_BITS > WGT_W) ? DIST_BITS : WGT_W;
   localparam int OX_W   = (DIST_BITS > OUT_W) ? DIST_BITS : OUT_W;
   localparam logic [DIST_BITS-1:0] INF = '1;

   // control registers
   st_type              state_ff, state_in;
   logic                init_ff, init_in;
   logic                rsp_strobe_ff;
   logic [IDX_W-1:0]    i_ff, i_in;
   logic [IDX_W-1:0]    j_ff, j_in;
   logic [IDX_W-1:0]    k_ff, k_in;
   logic [ADDR_W-1:0]   clr_ff, clr_in;
   logic [NC_W-1:0]     node_count_ff;

   // payload registers
   req_type             req_ff;
   logic [DIST_BITS-1:0] ik_ff;
   logic [DIST_BITS-1:0] sum_ff;
   logic [DIST_BITS-1:0] ij_ff;
   logic                ba_wr_ff;
   rsp_type             rsp_data_ff;

   // memory port
   logic                ram_we;
   logic [ADDR_W-1:0]   ram_waddr;
   logic [DIST_BITS-1:0] ram_wdata;
   logic [ADDR_W-1:0]   rd0_addr;
   logic [ADDR_W-1:0]   rd1_addr;
   logic [DIST_BITS-1:0] rd0_data;
   logic [DIST_BITS-1:0] rd1_data;

   // derived values
   logic                accept;
   logic                csr_wr;
   logic [CMP_W-1:0]    n_ext;
   logic [CMP_W-1:0]    last_ext;
   logic                n_zero;
   logic [CMP_W-1:0]    a_ext;
   logic [CMP_W-1:0]    b_ext;
   logic [IDX_W-1:0]    a_idx;
   logic [IDX_W-1:0]    b_idx;
   logic                in_range;
   logic                i_last;
   logic                j_last;
   logic                k_last;
   logic                all_last;
   logic                clr_done;
   logic                ik_inf;
   logic [EXT_W-1:0]    w_ext;
   logic [DIST_BITS-1:0] edge_val;
   logic [DIST_BITS:0]  raw_sum;
   logic [DIST_BITS-1:0] sat_sum;
   logic [OX_W-1:0]     q_ext;
   logic                qry_ok;

   apsp_ram #(
      .ADDR_W (ADDR_W),
      .DATA_W (DIST_BITS)
   ) u_ram (
      .clock    (clock),
      .wr_en    (ram_we),
      .wr_addr  (ram_waddr),
      .wr_data  (ram_wdata),
      .rd0_addr (rd0_addr),
      .rd0_data (rd0_data),
      .rd1_addr (rd1_addr),
      .rd1_data (rd1_data)
   );

   // ---------------------------------------------------------------- config
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && (paddr[2] == CSR_IDX_NODE_COUNT);

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NC_W'(64);
      end else if (csr_wr) begin
         node_count_ff <= pwdata[NC_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == CSR_IDX_NODE_COUNT) begin
         prdata = 32'(node_count_ff);
      end
   end

   // ---------------------------------------------------------- shared terms
   assign accept = start && !busy;

   // nodes in use, clamped to the matrix size
   always_comb begin
      n_ext = CMP_W'(node_count_ff);
      if (n_ext > CMP_W'(MAX_NODES)) begin
         n_ext = CMP_W'(MAX_NODES);
      end
   end

   assign last_ext = n_ext - CMP_W'(1);
   assign n_zero   = (n_ext == '0);
   assign a_ext    = CMP_W'(req_ff.node_a);
   assign b_ext    = CMP_W'(req_ff.node_b);
   assign a_idx    = a_ext[IDX_W-1:0];
   assign b_idx    = b_ext[IDX_W-1:0];
   assign in_range = (a_ext < n_ext) && (b_ext < n_ext);

   assign i_last   = (CMP_W'(i_ff) == last_ext);
   assign j_last   = (CMP_W'(j_ff) == last_ext);
   assign k_last   = (CMP_W'(k_ff) == last_ext);
   assign all_last = i_last && k_last;
   assign clr_done = (clr_ff == '1);
   assign ik_inf   = (rd0_data == INF);

   // edge weight capped at infinity
   assign w_ext    = EXT_W'(req_ff.weight);
   assign edge_val = (w_ext >= EXT_W'(INF)) ? INF : w_ext[DIST_BITS-1:0];

   // shared saturating adder: d[i][k] + d[k][j]
   assign raw_sum = {1'b0, ik_ff} + {1'b0, rd0_data};
   assign sat_sum = ((rd0_data == INF) || (raw_sum >= {1'b0, INF})) ?
                    INF : raw_sum[DIST_BITS-1:0];

   // query answer, cut to the output width
   assign q_ext  = OX_W'(rd0_data);
   assign qry_ok = in_range && (rd0_data != INF);

   // ------------------------------------------------------------ next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.func)
                  FUNC_CLEAR:   state_in = ST_CLEAR;
                  FUNC_EDGE:    state_in = ST_EDGE_RD;
                  FUNC_COMPUTE: state_in = n_zero ? ST_DONE : ST_DIAG;
                  FUNC_QUERY:   state_in = ST_QRY_RD;
                  default:      state_in = ST_DONE;
               endcase
            end
         end
         ST_CLEAR: begin
            if (clr_done) begin
               state_in = init_ff ? ST_IDLE : ST_DONE;
            end
         end
         ST_EDGE_RD:  state_in = ST_EDGE_WAB;
         ST_EDGE_WAB: state_in = ST_EDGE_WBA;
         ST_EDGE_WBA: state_in = ST_DONE;
         ST_QRY_RD:   state_in = ST_QRY_OUT;
         ST_QRY_OUT:  state_in = ST_DONE;
         ST_DIAG: begin
            if (i_last) begin
               state_in = ST_IK_RD;
            end
         end
         ST_IK_RD: state_in = ST_IK_CHK;
         ST_IK_CHK: begin
            if (!ik_inf) begin
               state_in = ST_J_RD;
            end else begin
               state_in = all_last ? ST_DONE : ST_IK_RD;
            end
         end
         ST_J_RD:  state_in = ST_J_ADD;
         ST_J_ADD: state_in = ST_J_CMP;
         ST_J_CMP: begin
            if (!j_last) begin
               state_in = ST_J_RD;
            end else begin
               state_in = all_last ? ST_DONE : ST_IK_RD;
            end
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // --------------------------------------------------------------- outputs
   always_comb begin
      busy      = 1'b1;
      ram_we    = 1'b0;
      ram_waddr = {a_idx, b_idx};
      ram_wdata = edge_val;
      rd0_addr  = {a_idx, b_idx};
      rd1_addr  = {b_idx, a_idx};
      case (state_ff)
         ST_IDLE: busy = 1'b0;
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = INF;
         end
         ST_EDGE_WAB: begin
            // lower weight wins over a parallel edge
            ram_we = in_range && (edge_val < rd0_data);
         end
         ST_EDGE_WBA: begin
            ram_we    = ba_wr_ff;
            ram_waddr = {b_idx, a_idx};
         end
         ST_DIAG: begin
            ram_we    = 1'b1;
            ram_waddr = {i_ff, i_ff};
            ram_wdata = '0;
         end
         ST_IK_RD: rd0_addr = {i_ff, k_ff};
         ST_J_RD: begin
            rd0_addr = {k_ff, j_ff};
            rd1_addr = {i_ff, j_ff};
         end
         ST_J_CMP: begin
            // relax d[i][j] through node k
            ram_we    = (sum_ff < ij_ff);
            ram_waddr = {i_ff, j_ff};
            ram_wdata = sum_ff;
         end
         default: ;
      endcase
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // -------------------------------------------------------------- counters
   always_comb begin
      i_in    = i_ff;
      j_in    = j_ff;
      k_in    = k_ff;
      clr_in  = clr_ff;
      init_in = init_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               i_in   = '0;
               j_in   = '0;
               k_in   = '0;
               clr_in = '0;
            end
         end
         ST_CLEAR: begin
            clr_in = clr_ff + ADDR_W'(1);
            if (clr_done) begin
               init_in = 1'b0;
            end
         end
         ST_DIAG: i_in = i_last ? '0 : i_ff + IDX_W'(1);
         ST_IK_CHK: begin
            // row with no path to k: nothing to relax
            if (ik_inf) begin
               if (i_last) begin
                  i_in = '0;
                  k_in = k_ff + IDX_W'(1);
               end else begin
                  i_in = i_ff + IDX_W'(1);
               end
            end
         end
         ST_J_CMP: begin
            if (j_last) begin
               j_in = '0;
               if (i_last) begin
                  i_in = '0;
                  k_in = k_ff + IDX_W'(1);
               end else begin
                  i_in = i_ff + IDX_W'(1);
               end
            end else begin
               j_in = j_ff + IDX_W'(1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         init_ff       <= 1'b1;
         rsp_strobe_ff <= 1'b0;
         i_ff          <= '0;
         j_ff          <= '0;
         k_ff          <= '0;
         clr_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         init_ff       <= init_in;
         rsp_strobe_ff <= (state_ff == ST_DONE);
         i_ff          <= i_in;
         j_ff          <= j_in;
         k_ff          <= k_in;
         clr_ff        <= clr_in;
      end
   end

   // -------------------------------------------------------------- datapath
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff      <= req_data;
         rsp_data_ff <= '0;
      end
      if (state_ff == ST_QRY_OUT) begin
         rsp_data_ff.distance  <= qry_ok ? q_ext[OUT_W-1:0] : '1;
         rsp_data_ff.reachable <= qry_ok;
      end
      if (state_ff == ST_EDGE_WAB) begin
         ba_wr_ff <= in_range && (edge_val < rd1_data);
      end
      if (state_ff == ST_IK_CHK) begin
         ik_ff <= rd0_data;
      end
      if (state_ff == ST_J_ADD) begin
         sum_ff <= sat_sum;
         ij_ff  <= rd1_data;
      end
   end

`ifndef SYNTHESIS
   // one result per item; the result strobe never stays high
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   // a taken item keeps the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("block not busy after taking an item");

   // results appear only once the block is ready again
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while busy");

   // only queries carry a nonzero answer
   a_nonquery_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (req_ff.func != FUNC_QUERY) |-> (rsp_data == '0))
      else $error("nonzero result for a non-query item");

   // relaxation never runs with no nodes in use
   a_sweep_nodes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIAG) || (state_ff == ST_J_RD) |-> !n_zero)
      else $error("matrix sweep with zero nodes");
`endif

endmodule
